@@ hdl/sorted_top_k_list_top_assert.svh @@
// Assertion macros used by the checker file srtk_checker.sv.
`ifndef SORTED_TOP_K_LIST_TOP_ASSERT_SVH
`define SORTED_TOP_K_LIST_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define SRTK_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define SRTK_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/srtk_pkg.sv @@
package srtk_pkg;

	localparam int CAPACITY_RESET = 10;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_READ   = 2'd2
	} req_type_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_LOW    = 2'd1,
		ST_BADIDX = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [31:0] score;
		logic [15:0]        tag;
	} entry_t;

	typedef struct packed {
		logic               ins;
		logic               rem;
		logic signed [31:0] score;
		logic [15:0]        tag;
	} cell_ctl_t;

endpackage

@@ hdl/srtk_req_if.sv @@
interface srtk_req_if import srtk_pkg::*; ();
	logic               valid;
	logic               ready;
	req_type_t          req_type;
	logic signed [31:0] new_score;
	logic [15:0]        new_tag;
	logic [3:0]         position;

	modport source (output valid, output req_type, output new_score, output new_tag,
		output position, input ready);
	modport sink (input valid, input req_type, input new_score, input new_tag,
		input position, output ready);
endinterface

@@ hdl/srtk_rsp_if.sv @@
interface srtk_rsp_if import srtk_pkg::*; ();
	logic               valid;
	logic               ready;
	status_t            status;
	logic signed [31:0] out_score;
	logic [15:0]        out_tag;
	logic [4:0]         fill;

	modport source (output valid, output status, output out_score, output out_tag,
		output fill, input ready);
	modport sink (input valid, input status, input out_score, input out_tag,
		input fill, output ready);
endinterface

@@ hdl/srtk_cfg_if.sv @@
interface srtk_cfg_if import srtk_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [4:0] capacity;

	modport source (output valid, output capacity, input ready);
	modport sink (input valid, input capacity, output ready);
endinterface

@@ hdl/srtk_cell.sv @@
module srtk_cell import srtk_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      valid,
	input  logic      at_or_after,
	input  logic      take_prev,
	input  entry_t    prev,
	input  entry_t    next,
	output entry_t    data,
	output logic      take
);

	entry_t data_q;

	assign data = data_q;
	assign take = !valid || ($signed(ctl.score) > $signed(data_q.score));

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (take && !take_prev) begin
				data_q.score <= ctl.score;
				data_q.tag   <= ctl.tag;
			end else if (take) begin
				data_q <= prev;
			end
		end else if (ctl.rem && at_or_after) begin
			data_q <= next;
		end
	end

endmodule

@@ hdl/sorted_top_k_list_top.sv @@
// Channel  Dir  Beat
// req      in   req_type, new_score, new_tag, position
// rsp      out  status, out_score, out_tag, fill
// cfg      in   capacity (always ready)
//
// One request per cycle while req is not stalled: every cell compares and shifts in the same cycle.
// A result lands in the rsp register in the cycle after its request beat.
// req stalls only while a result waits in the rsp register and rsp.ready is low.
// arst_n empties the list and sets capacity to 10 (limited to MAX_DEPTH).
module sorted_top_k_list_top import srtk_pkg::*; #(
	parameter int MAX_DEPTH = 16
) (
	input logic         clk,
	input logic         arst_n,
	srtk_req_if.sink    req,
	srtk_rsp_if.source  rsp,
	srtk_cfg_if.sink    cfg
);

	localparam int OW       = $clog2(MAX_DEPTH + 1);
	localparam int CapReset = (CAPACITY_RESET > MAX_DEPTH) ? MAX_DEPTH : CAPACITY_RESET;

	logic [OW-1:0]        occupied_q;
	logic [OW-1:0]        cap_q;
	logic [OW-1:0]        cap_d;
	logic [OW-1:0]        occ_nxt;
	logic                 rsp_valid_q;
	status_t              status_q;
	logic signed [31:0]   score_q;
	logic [15:0]          tag_q;
	logic [4:0]           fill_q;

	entry_t               data [MAX_DEPTH];
	logic [MAX_DEPTH-1:0] take;
	logic [MAX_DEPTH-1:0] valid;
	logic [MAX_DEPTH-1:0] at_or_after;
	entry_t               rd_entry;
	cell_ctl_t            ctl;
	logic                 acc;
	logic                 full;
	logic                 ins_ok;
	logic                 pos_ok;
	status_t              status_d;
	entry_t               out_d;

	assign acc       = req.valid && req.ready;
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign cfg.ready = 1'b1;

	assign full   = occupied_q >= cap_q;
	assign ins_ok = !full || (|(take & valid));
	assign pos_ok = int'(req.position) < int'(occupied_q);

	assign ctl.ins   = acc && (req.req_type == REQ_INSERT) && ins_ok;
	assign ctl.rem   = acc && (req.req_type == REQ_REMOVE) && pos_ok;
	assign ctl.score = req.new_score;
	assign ctl.tag   = req.new_tag;

	for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
		entry_t prev_e;
		entry_t next_e;
		logic   take_p;

		assign valid[i]       = i < int'(occupied_q);
		assign at_or_after[i] = i >= int'(req.position);

		if (i == 0) begin : g_first
			assign prev_e = '0;
			assign take_p = 1'b0;
		end else begin : g_inner
			assign prev_e = data[i-1];
			assign take_p = take[i-1];
		end

		if (i == MAX_DEPTH - 1) begin : g_last
			assign next_e = data[i];
		end else begin : g_mid
			assign next_e = data[i+1];
		end

		srtk_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.valid       (valid[i]),
			.at_or_after (at_or_after[i]),
			.take_prev   (take_p),
			.prev        (prev_e),
			.next        (next_e),
			.data        (data[i]),
			.take        (take[i])
		);
	end

	always_comb begin
		rd_entry = '0;
		for (int i = 0; i < MAX_DEPTH; i++) begin
			if (i == int'(req.position)) begin
				rd_entry = rd_entry | data[i];
			end
		end
	end

	always_comb begin
		status_d = ST_DONE;
		out_d    = '0;
		occ_nxt  = occupied_q;
		case (req.req_type)
			REQ_INSERT: begin
				if (!ins_ok) begin
					status_d = ST_LOW;
				end else if (!full) begin
					occ_nxt = occupied_q + OW'(1);
				end
			end
			REQ_REMOVE: begin
				if (pos_ok) begin
					out_d   = rd_entry;
					occ_nxt = occupied_q - OW'(1);
				end else begin
					status_d = ST_BADIDX;
				end
			end
			REQ_READ: begin
				if (pos_ok) begin
					out_d = rd_entry;
				end else begin
					status_d = ST_BADIDX;
				end
			end
			default: begin
				status_d = ST_DONE;
			end
		endcase
	end

	always_comb begin
		if (cfg.capacity == '0) begin
			cap_d = OW'(1);
		end else if (int'(cfg.capacity) > MAX_DEPTH) begin
			cap_d = OW'(MAX_DEPTH);
		end else begin
			cap_d = OW'(cfg.capacity);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupied_q  <= '0;
			cap_q       <= OW'(CapReset);
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				cap_q <= cap_d;
				if (occupied_q > cap_d) begin
					occupied_q <= cap_d;
				end
			end else if (acc) begin
				occupied_q <= occ_nxt;
			end
			if (acc) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_q <= status_d;
			score_q  <= out_d.score;
			tag_q    <= out_d.tag;
			fill_q   <= 5'(occ_nxt);
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = status_q;
	assign rsp.out_score = score_q;
	assign rsp.out_tag   = tag_q;
	assign rsp.fill      = fill_q;

endmodule

@@ hdl/srtk_checker.sv @@
`include "sorted_top_k_list_top_assert.svh"

module srtk_checker import srtk_pkg::*; #(
	parameter int MAX_DEPTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  status,
	input logic [31:0] out_score,
	input logic [15:0] out_tag,
	input logic [4:0]  fill
);

	`SRTK_ASSERT_NEXT(a_beat_gives_result, req_valid && req_ready, rsp_valid, "request beat gave no result")
	`SRTK_ASSERT_IMP(a_stall_blocks_req, rsp_valid && !rsp_ready, !req_ready, "request taken while result stalled")
	`SRTK_ASSERT_IMP(a_error_zero_data, rsp_valid && (status != ST_DONE), (out_score == '0) && (out_tag == '0), "error result carries data")
	`SRTK_ASSERT_IMP(a_fill_bound, rsp_valid, int'(fill) <= MAX_DEPTH, "fill beyond depth")
	`SRTK_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(out_score) && $stable(out_tag) && $stable(fill), "stalled result changed")

endmodule

bind sorted_top_k_list_top srtk_checker #(.MAX_DEPTH(MAX_DEPTH)) u_srtk_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.status    (rsp.status),
	.out_score (rsp.out_score),
	.out_tag   (rsp.out_tag),
	.fill      (rsp.fill)
);
